>>> design/b64e_pkg.sv
// Shared types and constants for the base64 stream encoder.
// Holds the job record passed from front to back and the digit lookup.
// No dependencies.
package b64e_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned JOB_CHARS = 4;
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef struct packed {
		logic [JOB_CHARS-1:0][7:0] chars;
		logic [1:0] last_idx;
		logic final_mark;
	} job_t;

	function automatic logic [7:0] digit_char(input logic [5:0] six);
		logic [7:0] v;
		logic [7:0] c;
		v = {2'b00, six};
		if (six < 6'd26) begin
			c = v + 8'h41;
		end else if (six < 6'd52) begin
			c = v - 8'd26 + 8'h61;
		end else if (six < 6'd62) begin
			c = v - 8'd52 + 8'h30;
		end else if (six == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

endpackage

>>> design/b64e_front.sv
// Front end of the base64 stream encoder: accepts raw byte beats, tracks
// the group phase and leftover bits, and builds one character job per byte.
// Depends on b64e_pkg.
module b64e_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     data_byte,
	input  logic           final_byte,
	input  logic           queue_full,
	output logic           push,
	output b64e_pkg::job_t push_job
);
	import b64e_pkg::*;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD  = 2'd2
	} phase_t;

	phase_t     phase_q;
	phase_t     phase_next;
	logic [5:0] left_q;
	logic [5:0] left_next;

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		push_job.final_mark = final_byte;
		push_job.chars[2]   = PAD_CHAR;
		push_job.chars[3]   = PAD_CHAR;
		case (phase_q)
			PH_SECOND: begin
				push_job.chars[0] = digit_char(left_q | {2'b00, data_byte[7:4]});
				left_next         = {data_byte[3:0], 2'b00};
				push_job.chars[1] = digit_char(left_next);
				push_job.last_idx = final_byte ? 2'd2 : 2'd0;
				phase_next        = PH_THIRD;
			end
			PH_THIRD: begin
				push_job.chars[0] = digit_char(left_q | {4'b0000, data_byte[7:6]});
				push_job.chars[1] = digit_char(data_byte[5:0]);
				left_next         = 6'd0;
				push_job.last_idx = 2'd1;
				phase_next        = PH_FIRST;
			end
			default: begin
				push_job.chars[0] = digit_char(data_byte[7:2]);
				left_next         = {data_byte[1:0], 4'b0000};
				push_job.chars[1] = digit_char(left_next);
				push_job.last_idx = final_byte ? 2'd3 : 2'd0;
				phase_next        = PH_SECOND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			left_q  <= 6'd0;
		end else if (push) begin
			if (final_byte) begin
				phase_q <= PH_FIRST;
				left_q  <= 6'd0;
			end else begin
				phase_q <= phase_next;
				left_q  <= left_next;
			end
		end
	end

endmodule

>>> design/b64e_queue.sv
// Short job queue between front and back of the base64 stream encoder.
// Register-based circular buffer. Depends on b64e_pkg.
module b64e_queue #(
	parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64e_pkg::job_t push_job,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output b64e_pkg::job_t head_job
);
	import b64e_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/b64e_back.sv
// Back end of the base64 stream encoder: walks the characters of the head
// job into the output register, one per cycle while out_stall is low. Depends on b64e_pkg.
module b64e_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           queue_empty,
	input  b64e_pkg::job_t head_job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     out_char,
	output logic           end_of_message
);
	import b64e_pkg::*;

	logic       valid_q;
	logic [7:0] char_q;
	logic       eom_q;
	logic [1:0] idx_q;
	logic       advance;
	logic       at_last;

	assign advance = !queue_empty && (!valid_q || !out_stall);
	assign at_last = (idx_q == head_job.last_idx);
	assign pop     = advance && at_last;

	assign out_valid      = valid_q;
	assign out_char       = char_q;
	assign end_of_message = eom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (advance) begin
			valid_q <= 1'b1;
			idx_q   <= at_last ? 2'd0 : idx_q + 2'd1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			char_q <= head_job.chars[idx_q];
			eom_q  <= head_job.final_mark && at_last;
		end
	end

endmodule

>>> design/base64_stream_encoder.sv
// Top level of the base64 stream encoder: front end, job queue, back end.
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
//
// Input channel: in_valid / in_stall carry one raw byte per beat in data_byte,
// with final_byte set on the last byte of a message.
// Output channel: out_valid / out_stall carry one ASCII character per beat in
// out_char; end_of_message marks the last character of the message, after
// any '=' padding.
// Each byte yields one character (first and second of a group) or two (third
// of a group); a final first or second byte yields four or three. The back end
// sends one character per cycle while out_stall is low: four characters per
// three bytes in steady state, plus the padding burst at message end.
// When the queue is empty, an accepted byte's job is written into the queue
// and its first character then into the output register.
// The front end accepts a byte whenever the job queue (QUEUE_DEPTH jobs) has
// room, also while the output register waits on out_stall. A stalled output
// holds its character until taken; the queue then fills and in_stall rises.
// Reset clears the group phase, leftover bits, queue and output valid.
module base64_stream_encoder #(
	parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       end_of_message
);
	import b64e_pkg::*;

	logic queue_full;
	logic queue_empty;
	logic push;
	logic pop;
	job_t push_job;
	job_t head_job;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (queue_full),
		.empty    (queue_empty),
		.head_job (head_job)
	);

	b64e_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.queue_empty    (queue_empty),
		.head_job       (head_job),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_char       (out_char),
		.end_of_message (end_of_message)
	);

endmodule

>>> test/base64_stream_encoder_tb.sv
// Testbench for base64_stream_encoder: directed group-edge, drain-pause and random messages.
// Every accepted character is checked against the encoding computed here.
// Depends on design/base64_stream_encoder.sv and its submodules.
module base64_stream_encoder_tb;

	localparam logic [8*64-1:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam logic [7:0] PAD_ASCII = 8'h3D;
	localparam logic [1:0] GROUP_FIRST = 2'd0;
	localparam logic [1:0] GROUP_SECOND = 2'd1;
	localparam logic [1:0] GROUP_THIRD = 2'd2;
	localparam logic [1:0] GROUP_INVALID = 2'd3;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		logic [7:0] ch;
		logic eom;
	} char_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] data_byte = 8'h00;
	logic final_byte = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_char;
	logic end_of_message;

	char_beat_t expected_chars[$];
	logic [1:0] group_phase = GROUP_FIRST;
	logic [5:0] leftover = 6'd0;
	int in_idle_pct = 0;
	int out_stall_pct = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	base64_stream_encoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.final_byte(final_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.end_of_message(end_of_message)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [7:0] b64_digit(input logic [5:0] six);
		return B64_ALPHABET[8 * (63 - six) +: 8];
	endfunction

	task automatic encode_byte(input logic [7:0] b, input logic fin);
		logic [7:0] chars [4];
		int n;
		int k;
		n = 0;
		if (group_phase == GROUP_INVALID) begin
			group_phase = GROUP_FIRST;
			leftover = 6'd0;
		end
		case (group_phase)
			GROUP_FIRST: begin
				chars[0] = b64_digit(b[7:2]);
				leftover = {b[1:0], 4'b0000};
				group_phase = GROUP_SECOND;
				n = 1;
				if (fin) begin
					chars[1] = b64_digit(leftover);
					chars[2] = PAD_ASCII;
					chars[3] = PAD_ASCII;
					n = 4;
				end
			end
			GROUP_SECOND: begin
				chars[0] = b64_digit(leftover | {2'b00, b[7:4]});
				leftover = {b[3:0], 2'b00};
				group_phase = GROUP_THIRD;
				n = 1;
				if (fin) begin
					chars[1] = b64_digit(leftover);
					chars[2] = PAD_ASCII;
					n = 3;
				end
			end
			default: begin
				chars[0] = b64_digit(leftover | {4'b0000, b[7:6]});
				chars[1] = b64_digit(b[5:0]);
				leftover = 6'd0;
				group_phase = GROUP_FIRST;
				n = 2;
			end
		endcase
		if (fin) begin
			group_phase = GROUP_FIRST;
			leftover = 6'd0;
		end
		for (k = 0; k < n; k++)
			expected_chars.push_back('{ch: chars[k], eom: fin && (k == n - 1)});
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			data_byte <= 8'($urandom_range(255));
			final_byte <= 1'($urandom_range(1));
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		final_byte <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		encode_byte(b, fin);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_chars.size() != 0);
	endtask

	task automatic test_group_edges();
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFC, 1'b0);
		send_byte(8'h0F, 1'b0);
		send_byte(8'hC0, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'hF0, 1'b1);
		send_byte(8'hFB, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hA5, 1'b1);
	endtask

	task automatic test_pause_until_drained();
		int len;
		int k;
		for (len = 1; len <= 4; len++) begin
			for (k = 0; k < len; k++)
				send_byte(8'($urandom_range(255)), k == len - 1);
			wait_drained();
		end
	endtask

	task automatic test_random_messages(input int n_bytes);
		int sent;
		int len;
		int k;
		sent = 0;
		while (sent < n_bytes) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
			for (k = 0; k < len; k++)
				send_byte(8'($urandom_range(255)), k == len - 1);
			sent += len;
		end
	endtask

	always @(posedge clk) begin
		char_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_chars.size() == 0) begin
				$display("%0t unexpected beat: expected none, actual char %h eom %b",
					$time, out_char, end_of_message);
				mismatches++;
			end else begin
				want = expected_chars.pop_front();
				if (out_char !== want.ch) begin
					$display("%0t out_char mismatch: expected %h, actual %h",
						$time, want.ch, out_char);
					mismatches++;
				end
				if (end_of_message !== want.eom) begin
					$display("%0t end_of_message mismatch: expected %b, actual %b",
						$time, want.eom, end_of_message);
					mismatches++;
				end
			end
		end
		out_stall <= ($urandom_range(99) < out_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no beat for %0d cycles", $time, idle_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		in_idle_pct = 33;
		out_stall_pct = 47;
		test_group_edges();
		test_random_messages(75);

		in_idle_pct = 47;
		out_stall_pct = 33;
		test_pause_until_drained();
		test_random_messages(75);

		in_idle_pct = 0;
		out_stall_pct = 0;
		test_random_messages(75);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> files.f
design/b64e_pkg.sv
design/b64e_front.sv
design/b64e_queue.sv
design/b64e_back.sv
design/base64_stream_encoder.sv
test/base64_stream_encoder_tb.sv
